### rtl/core/fomix_pkg.sv
// shared types, widths and constants for the three-wheel field-oriented mixer
// used by the cordic cell, the drive lane and the top level
package fomix_pkg;

    localparam int XW           = 34;
    localparam int ZW           = 33;
    localparam int PW32         = 32;
    localparam int TW           = 47;
    localparam int SW           = 49;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [XW-1:0] CORDIC_K   = 34'sd652032874;
    localparam logic signed [ZW-1:0] QUARTER    = 33'sd1073741824;
    localparam logic signed [ZW-1:0] HALF_TURN  = 33'sd2147483648;
    localparam logic signed [15:0]   SIN60_Q15  = 16'sd28378;
    localparam logic [15:0]          RECIP3     = 16'd43691;
    localparam logic [16:0]          SAT_MAG    = 17'd98304;

    localparam logic [15:0] GAIN_A_RST = 16'd19661;
    localparam logic [15:0] GAIN_B_RST = 16'd22938;
    localparam logic [15:0] GAIN_C_RST = 16'd18022;

    localparam int REG_IDX_W = 8;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_A = 8'd0,
        REG_GAIN_B = 8'd1,
        REG_GAIN_C = 8'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [15:0] rot;
        logic               half;
    } side_t;

    function automatic logic [PW32-1:0] atan_turn(input int unsigned idx);
        logic [PW32-1:0] a;
        case (idx)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/core/field_oriented_three_omni_wheel_mix.sv
// Takes one word per cycle and gives one result word per cycle when the output side
// keeps up; the word lands in the fold register at the accepting edge, then passes through
// each cordic cell (at most 24), one rotation per cell, and then through rounding, the
// two speed product stages, the sums, the four-stage gain and divide lanes and the
// output register. Every stage moves on its own, so bubbles are squeezed out and words
// keep entering while a result waits at the output. The user must write gain registers
// only at times the block is idle, which the block itself does not enforce; a gain
// written then takes effect on the next word.
module field_oriented_three_omni_wheel_mix #(
    parameter int ANGLE_BITS  = 16,
    parameter int TRIG_STAGES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fomix_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [15:0]                           heading,
    input  logic signed [15:0]                    travel_speed,
    input  logic [14:0]                           turn_ccw,
    input  logic [14:0]                           turn_cw,
    input  logic [15:0]                           gyro_heading,
    input  logic                                  half_speed,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [15:0]                    wheel_a,
    output logic signed [15:0]                    wheel_b,
    output logic signed [15:0]                    wheel_c
);

    localparam int NCELL = (TRIG_STAGES > fomix_pkg::ATAN_ENTRIES) ?
                           fomix_pkg::ATAN_ENTRIES : TRIG_STAGES;
    localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

    localparam int T_RND = 0;
    localparam int T_M1  = 1;
    localparam int T_M2  = 2;
    localparam int T_SUM = 3;
    localparam int T_D1  = 4;
    localparam int T_OUT = 8;
    localparam int NT    = 9;

    // gain registers
    logic [15:0] gain_a_reg;
    logic [15:0] gain_b_reg;
    logic [15:0] gain_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_a_reg <= fomix_pkg::GAIN_A_RST;
            gain_b_reg <= fomix_pkg::GAIN_B_RST;
            gain_c_reg <= fomix_pkg::GAIN_C_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fomix_pkg::REG_GAIN_A: gain_a_reg <= cfg_data;
                fomix_pkg::REG_GAIN_B: gain_b_reg <= cfg_data;
                fomix_pkg::REG_GAIN_C: gain_c_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // fold stage
    logic                               f_valid_reg;
    logic signed [fomix_pkg::XW-1:0]    f_x_reg;
    logic signed [fomix_pkg::ZW-1:0]    f_z_reg;
    fomix_pkg::side_t                   f_side_reg;

    logic [15:0]                        diff;
    logic [31:0]                        phase;
    logic signed [fomix_pkg::ZW-1:0]    zs;
    logic signed [fomix_pkg::XW-1:0]    f_x_next;
    logic signed [fomix_pkg::ZW-1:0]    f_z_next;
    fomix_pkg::side_t                   f_side_next;

    logic                               cv [NCELL+1];
    logic                               cr [NCELL+1];
    logic signed [fomix_pkg::XW-1:0]    cx [NCELL+1];
    logic signed [fomix_pkg::XW-1:0]    cy [NCELL+1];
    logic signed [fomix_pkg::ZW-1:0]    cz [NCELL+1];
    fomix_pkg::side_t                   cs [NCELL+1];

    assign in_ready = !f_valid_reg || cr[0];

    always_comb
    begin
        diff  = heading - gyro_heading;
        phase = {diff, 16'h0000} & PHASE_MASK;
        zs    = $signed({phase[31], phase});
        if (zs > fomix_pkg::QUARTER)
        begin
            f_x_next = -fomix_pkg::CORDIC_K;
            f_z_next = zs - fomix_pkg::HALF_TURN;
        end
        else if (zs < -fomix_pkg::QUARTER)
        begin
            f_x_next = -fomix_pkg::CORDIC_K;
            f_z_next = zs + fomix_pkg::HALF_TURN;
        end
        else
        begin
            f_x_next = fomix_pkg::CORDIC_K;
            f_z_next = zs;
        end
        f_side_next.speed = travel_speed;
        f_side_next.rot   = $signed({1'b0, turn_ccw}) - $signed({1'b0, turn_cw});
        f_side_next.half  = half_speed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            f_x_reg    <= f_x_next;
            f_z_reg    <= f_z_next;
            f_side_reg <= f_side_next;
        end
    end

    // cordic chain
    assign cv[0] = f_valid_reg;
    assign cx[0] = f_x_reg;
    assign cy[0] = '0;
    assign cz[0] = f_z_reg;
    assign cs[0] = f_side_reg;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        fomix_cordic_cell #(
            .STAGE(g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[g]),
            .in_ready  (cr[g]),
            .x_in      (cx[g]),
            .y_in      (cy[g]),
            .z_in      (cz[g]),
            .side_in   (cs[g]),
            .out_valid (cv[g+1]),
            .out_ready (cr[g+1]),
            .x_out     (cx[g+1]),
            .y_out     (cy[g+1]),
            .z_out     (cz[g+1]),
            .side_out  (cs[g+1])
        );
    end

    // tail stages
    logic [NT-1:0] vld_reg;
    logic [NT-1:0] vld_next;
    logic [NT-1:0] adv;

    always_comb
    begin
        adv[NT-1] = !vld_reg[NT-1] || out_ready;
        for (int k = NT - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? cv[NCELL] : vld_reg[0];
        for (int k = 1; k < NT; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign cr[NCELL] = adv[T_RND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    function automatic logic signed [15:0] round_q15(input logic signed [fomix_pkg::XW-1:0] v);
        logic signed [fomix_pkg::XW-1:0] r;
        logic signed [15:0]              q;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)
        begin
            q = 16'sd32767;
        end
        else if (r < -34'sd32768)
        begin
            q = -16'sd32768;
        end
        else
        begin
            q = r[15:0];
        end
        return q;
    endfunction

    logic signed [15:0]               c_reg;
    logic signed [15:0]               s_reg;
    fomix_pkg::side_t                 r_side_reg;
    logic signed [31:0]               pc_reg;
    logic signed [31:0]               ps_reg;
    logic signed [15:0]               m1_rot_reg;
    logic                             m1_half_reg;
    logic signed [fomix_pkg::TW-1:0]  tcos_reg;
    logic signed [fomix_pkg::TW-1:0]  tsin_reg;
    logic signed [15:0]               m2_rot_reg;
    logic                             m2_half_reg;
    logic signed [fomix_pkg::SW-1:0]  sa_reg;
    logic signed [fomix_pkg::SW-1:0]  sb_reg;
    logic signed [fomix_pkg::SW-1:0]  sc_reg;
    logic                             s_half_reg;

    logic signed [31:0]               pc_next;
    logic signed [31:0]               ps_next;
    logic signed [fomix_pkg::TW-1:0]  tcos_next;
    logic signed [fomix_pkg::TW-1:0]  tsin_next;
    logic signed [fomix_pkg::SW-1:0]  tc_w;
    logic signed [fomix_pkg::SW-1:0]  ts_w;
    logic signed [fomix_pkg::SW-1:0]  tr_w;
    logic signed [fomix_pkg::SW-1:0]  sa_next;
    logic signed [fomix_pkg::SW-1:0]  sb_next;
    logic signed [fomix_pkg::SW-1:0]  sc_next;

    always_comb
    begin
        pc_next   = r_side_reg.speed * c_reg;
        ps_next   = r_side_reg.speed * s_reg;
        tcos_next = fomix_pkg::TW'(pc_reg) <<< 14;
        tsin_next = fomix_pkg::TW'(ps_reg) * fomix_pkg::TW'(fomix_pkg::SIN60_Q15);
        tc_w      = fomix_pkg::SW'(tcos_reg);
        ts_w      = fomix_pkg::SW'(tsin_reg);
        tr_w      = fomix_pkg::SW'(m2_rot_reg) <<< 30;
        sa_next   = tc_w + ts_w + tr_w;
        sb_next   = tc_w - ts_w + tr_w;
        sc_next   = tr_w - (tc_w <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv[T_RND])
        begin
            c_reg      <= round_q15(cx[NCELL]);
            s_reg      <= round_q15(cy[NCELL]);
            r_side_reg <= cs[NCELL];
        end
        if (adv[T_M1])
        begin
            pc_reg      <= pc_next;
            ps_reg      <= ps_next;
            m1_rot_reg  <= r_side_reg.rot;
            m1_half_reg <= r_side_reg.half;
        end
        if (adv[T_M2])
        begin
            tcos_reg    <= tcos_next;
            tsin_reg    <= tsin_next;
            m2_rot_reg  <= m1_rot_reg;
            m2_half_reg <= m1_half_reg;
        end
        if (adv[T_SUM])
        begin
            sa_reg     <= sa_next;
            sb_reg     <= sb_next;
            sc_reg     <= sc_next;
            s_half_reg <= m2_half_reg;
        end
    end

    // wheel lanes
    logic signed [15:0] lane_a;
    logic signed [15:0] lane_b;
    logic signed [15:0] lane_c;
    logic [3:0]         lane_en;

    assign lane_en = adv[T_D1 +: 4];

    fomix_drive u_drive_a (
        .clk      (clk),
        .stage_en (lane_en),
        .sum      (sa_reg),
        .gain     (gain_a_reg),
        .half     (s_half_reg),
        .wheel    (lane_a)
    );

    fomix_drive u_drive_b (
        .clk      (clk),
        .stage_en (lane_en),
        .sum      (sb_reg),
        .gain     (gain_b_reg),
        .half     (s_half_reg),
        .wheel    (lane_b)
    );

    fomix_drive u_drive_c (
        .clk      (clk),
        .stage_en (lane_en),
        .sum      (sc_reg),
        .gain     (gain_c_reg),
        .half     (s_half_reg),
        .wheel    (lane_c)
    );

    // output word
    logic signed [15:0] wheel_a_reg;
    logic signed [15:0] wheel_b_reg;
    logic signed [15:0] wheel_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv[T_OUT])
        begin
            wheel_a_reg <= lane_a;
            wheel_b_reg <= lane_b;
            wheel_c_reg <= lane_c;
        end
    end

    assign out_valid = vld_reg[T_OUT];
    assign wheel_a   = wheel_a_reg;
    assign wheel_b   = wheel_b_reg;
    assign wheel_c   = wheel_c_reg;

endmodule

### rtl/core/fomix_cordic_cell.sv
// one rotation cell of the cordic chain, holding x, y, residual angle and sideband
// depends on fomix_pkg
module fomix_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [fomix_pkg::XW-1:0]   x_in,
    input  logic signed [fomix_pkg::XW-1:0]   y_in,
    input  logic signed [fomix_pkg::ZW-1:0]   z_in,
    input  fomix_pkg::side_t                  side_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fomix_pkg::XW-1:0]   x_out,
    output logic signed [fomix_pkg::XW-1:0]   y_out,
    output logic signed [fomix_pkg::ZW-1:0]   z_out,
    output fomix_pkg::side_t                  side_out
);

    localparam logic signed [fomix_pkg::ZW-1:0] ATAN =
        $signed({{(fomix_pkg::ZW-fomix_pkg::PW32){1'b0}}, fomix_pkg::atan_turn(STAGE)});

    logic                              valid_reg;
    logic signed [fomix_pkg::XW-1:0]   x_reg;
    logic signed [fomix_pkg::XW-1:0]   y_reg;
    logic signed [fomix_pkg::ZW-1:0]   z_reg;
    fomix_pkg::side_t                  side_reg;

    logic signed [fomix_pkg::XW-1:0]   x_next;
    logic signed [fomix_pkg::XW-1:0]   y_next;
    logic signed [fomix_pkg::ZW-1:0]   z_next;
    logic signed [fomix_pkg::XW-1:0]   dx;
    logic signed [fomix_pkg::XW-1:0]   dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[fomix_pkg::ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

### rtl/core/fomix_drive.sv
// one wheel lane: trim gain product, truncating divide by three (and two), saturation
// depends on fomix_pkg; stage enables come from the top level
module fomix_drive (
    input  logic                              clk,
    input  logic [3:0]                        stage_en,
    input  logic signed [fomix_pkg::SW-1:0]   sum,
    input  logic [15:0]                       gain,
    input  logic                              half,
    output logic signed [15:0]                wheel
);

    logic [39:0]         pl_reg;
    logic signed [41:0]  ph_reg;
    logic                half1_reg;
    logic signed [65:0]  p_reg;
    logic                half2_reg;
    logic [16:0]         m_reg;
    logic                neg3_reg;
    logic [32:0]         prod_reg;
    logic                neg4_reg;

    logic [39:0]         pl_next;
    logic signed [41:0]  ph_next;
    logic signed [65:0]  p_next;
    logic [65:0]         mag;
    logic [21:0]         sh;
    logic [16:0]         m_next;
    logic [32:0]         prod_next;
    logic [15:0]         qm;
    logic [16:0]         qneg;

    always_comb
    begin
        pl_next   = 40'(sum[23:0]) * 40'(gain);
        ph_next   = 42'($signed(sum[fomix_pkg::SW-1:24])) * 42'($signed({1'b0, gain}));
        p_next    = (66'(ph_reg) <<< 24) + $signed({26'd0, pl_reg});
        mag       = p_reg[65] ? 66'(-p_reg) : 66'(p_reg);
        sh        = half2_reg ? 22'(mag >> 45) : 22'(mag >> 44);
        m_next    = (sh > 22'(fomix_pkg::SAT_MAG)) ? fomix_pkg::SAT_MAG : sh[16:0];
        prod_next = 33'(m_reg) * 33'(fomix_pkg::RECIP3);
        qm        = prod_reg[32:17];
        qneg      = 17'd0 - {1'b0, qm};
        if (neg4_reg)
        begin
            wheel = $signed(qneg[15:0]);
        end
        else if (qm[15])
        begin
            wheel = 16'sd32767;
        end
        else
        begin
            wheel = $signed(qm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            half1_reg <= half;
        end
        if (stage_en[1])
        begin
            p_reg     <= p_next;
            half2_reg <= half1_reg;
        end
        if (stage_en[2])
        begin
            m_reg    <= m_next;
            neg3_reg <= p_reg[65];
        end
        if (stage_en[3])
        begin
            prod_reg <= prod_next;
            neg4_reg <= neg3_reg;
        end
    end

endmodule

### rtl/core/fomix_check.sv
// port-level checker for the three-wheel mixer, counting words in flight
// bound to field_oriented_three_omni_wheel_mix at the end of this file
module fomix_check #(
    parameter int TRIG_STAGES = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] wheel_a,
    input logic signed [15:0] wheel_b,
    input logic signed [15:0] wheel_c
);

    localparam int NCELL = (TRIG_STAGES > 24) ? 24 : TRIG_STAGES;
    localparam int DEPTH = NCELL + 10;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
        begin
            cnt_next = cnt_next + CW'(1);
        end
        if (out_valid && out_ready)
        begin
            cnt_next = cnt_next - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // no result without a word in flight
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("result shown with no word in flight");

    // never more words than stages
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("more words in flight than stages");

    // empty pipe always takes a word
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> in_ready)
        else $error("empty pipe not ready");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wheel_a)
            && $stable(wheel_b) && $stable(wheel_c))
        else $error("stalled result changed");

endmodule

bind field_oriented_three_omni_wheel_mix fomix_check #(
    .TRIG_STAGES(TRIG_STAGES)
) u_fomix_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .wheel_a   (wheel_a),
    .wheel_b   (wheel_b),
    .wheel_c   (wheel_c)
);

### bench/field_oriented_three_omni_wheel_mix_test.sv
// self-checking bench for the three-wheel field-oriented mixer: a directed table, then
// random gain phases with bursty input and a stalling output, every word checked on arrival
// depends on fomix_pkg and rtl/core/field_oriented_three_omni_wheel_mix.sv
module field_oriented_three_omni_wheel_mix_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS  = 16;
    localparam int TRIG_STAGES = 16;
    localparam int LATENCY     = TRIG_STAGES + 9;
    localparam int LIMIT       = 400000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_WORDS = 180;

    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam longint SIN60       = 64'sd28378;
    localparam longint QUARTER     = 64'sd1073741824;
    localparam longint HALF_TURN   = 64'sd2147483648;
    localparam longint FULL_TURN   = 64'sd4294967296;

    localparam logic [15:0] TRIM_A_RST = 16'd19661;
    localparam logic [15:0] TRIM_B_RST = 16'd22938;
    localparam logic [15:0] TRIM_C_RST = 16'd18022;
    localparam logic [15:0] TRIM_UNITY = 16'd16384;

    localparam logic [fomix_pkg::REG_IDX_W-1:0] REG_UNUSED_LO = 8'd3;
    localparam logic [fomix_pkg::REG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;

    typedef struct packed {
        logic [15:0]        heading;
        logic signed [15:0] travel_speed;
        logic [14:0]        turn_ccw;
        logic [14:0]        turn_cw;
        logic [15:0]        gyro_heading;
        logic               half_speed;
    } command_t;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
    } wheels_t;

    typedef enum logic {ROW_WORD, ROW_GAIN} row_kind_t;

    typedef struct {
        row_kind_t                         kind;
        command_t                          cmd;
        logic                              fixed;
        wheels_t                           wheels;
        logic [fomix_pkg::REG_IDX_W-1:0]   idx;
        logic [15:0]                       data;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [fomix_pkg::REG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [15:0] heading;
    logic signed [15:0] travel_speed;
    logic [14:0] turn_ccw;
    logic [14:0] turn_cw;
    logic [15:0] gyro_heading;
    logic half_speed;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] wheel_a;
    logic signed [15:0] wheel_b;
    logic signed [15:0] wheel_c;

    longint arc_turn [0:23] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81
    };

    logic [15:0] trim_gain [0:2];
    wheels_t     pending_wheels [$];
    row_t        directed_rows [$];
    int          err_count;
    int          words_sent;
    int          results_checked;
    int          gain_writes;
    int          burst_left;
    int          ready_mode;
    int          ready_window;
    int          cycle_count;

    field_oriented_three_omni_wheel_mix #(
        .ANGLE_BITS  (ANGLE_BITS),
        .TRIG_STAGES (TRIG_STAGES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .heading      (heading),
        .travel_speed (travel_speed),
        .turn_ccw     (turn_ccw),
        .turn_cw      (turn_cw),
        .gyro_heading (gyro_heading),
        .half_speed   (half_speed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .wheel_a      (wheel_a),
        .wheel_b      (wheel_b),
        .wheel_c      (wheel_c)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint round_to_q15(input longint q30);
        longint r;
        r = (q30 + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
            r = 64'sd32767;
        if (r < -64'sd32768)
            r = -64'sd32768;
        return r;
    endfunction

    function automatic logic signed [15:0] trim_drive(input longint total,
                                                      input logic [15:0] gain,
                                                      input logic half);
        longint p;
        longint den;
        longint q;
        p = total * longint'({48'd0, gain});
        den = half ? (64'sd3 <<< 45) : (64'sd3 <<< 44);
        q = p / den;
        if (q > 64'sd32767)
            q = 64'sd32767;
        if (q < -64'sd32768)
            q = -64'sd32768;
        return q[15:0];
    endfunction

    function automatic wheels_t mix_wheels(input command_t cmd);
        logic [15:0] diff;
        logic [31:0] phase;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint c;
        longint s;
        longint v;
        longint r;
        longint t_cos;
        longint t_sin;
        longint t_rot;
        wheels_t w;
        diff = cmd.heading - cmd.gyro_heading;
        phase = {diff, 16'h0000} & (32'hFFFF_FFFF << (32 - ANGLE_BITS));
        z = longint'({32'd0, phase});
        if (z >= HALF_TURN)
            z = z - FULL_TURN;
        if (z > QUARTER)
        begin
            x = -CORDIC_GAIN;
            z = z - HALF_TURN;
        end
        else if (z < -QUARTER)
        begin
            x = -CORDIC_GAIN;
            z = z + HALF_TURN;
        end
        else
            x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < TRIG_STAGES && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arc_turn[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arc_turn[i];
            end
        end
        c = round_to_q15(x);
        s = round_to_q15(y);
        v = longint'($signed(cmd.travel_speed));
        r = longint'({49'd0, cmd.turn_ccw}) - longint'({49'd0, cmd.turn_cw});
        t_cos = v * c * 64'sd16384;
        t_sin = v * s * SIN60;
        t_rot = r * 64'sd1073741824;
        w.a = trim_drive(t_cos + t_sin + t_rot, trim_gain[0], cmd.half_speed);
        w.b = trim_drive(t_cos - t_sin + t_rot, trim_gain[1], cmd.half_speed);
        w.c = trim_drive(-64'sd2 * t_cos + t_rot, trim_gain[2], cmd.half_speed);
        return w;
    endfunction

    function automatic command_t random_command();
        command_t cmd;
        logic [15:0] quadrant;
        int pick;
        cmd = command_t'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            // headings right at the fold boundaries
            quadrant = 16'(($urandom_range(0, 3)) << 14);
            cmd.heading = cmd.gyro_heading + quadrant + 16'($urandom_range(0, 4)) - 16'd2;
        end
        else if (pick < 40)
        begin
            cmd.travel_speed = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            cmd.turn_ccw = $urandom_range(0, 1) ? 15'h7FFF : 15'(cmd.turn_ccw);
            cmd.turn_cw = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
        end
        else if (pick < 50)
        begin
            cmd.travel_speed = 16'($signed($urandom_range(0, 64)) - 32);
            cmd.turn_ccw = 15'($urandom_range(0, 16));
            cmd.turn_cw = 15'($urandom_range(0, 16));
        end
        return cmd;
    endfunction

    task automatic add_word(input logic [15:0] hd, input logic [15:0] sp,
                            input logic [14:0] ccw, input logic [14:0] cw,
                            input logic [15:0] gy, input logic hf);
        row_t row;
        row.kind = ROW_WORD;
        row.cmd = '{hd, sp, ccw, cw, gy, hf};
        row.fixed = 1'b0;
        row.wheels = '0;
        row.idx = '0;
        row.data = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_known(input logic [15:0] hd, input logic [15:0] sp,
                             input logic [14:0] ccw, input logic [14:0] cw,
                             input logic [15:0] gy, input logic hf,
                             input logic [15:0] ea, input logic [15:0] eb,
                             input logic [15:0] ec);
        add_word(hd, sp, ccw, cw, gy, hf);
        directed_rows[$].fixed = 1'b1;
        directed_rows[$].wheels = '{ea, eb, ec};
    endtask

    task automatic add_gain(input logic [fomix_pkg::REG_IDX_W-1:0] idx, input logic [15:0] data);
        row_t row;
        row.kind = ROW_GAIN;
        row.cmd = '0;
        row.fixed = 1'b0;
        row.wheels = '0;
        row.idx = idx;
        row.data = data;
        directed_rows.push_back(row);
    endtask

    task automatic send_word(input command_t cmd, input logic fixed, input wheels_t known);
        int gap;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        in_valid <= 1'b1;
        heading <= cmd.heading;
        travel_speed <= cmd.travel_speed;
        turn_ccw <= cmd.turn_ccw;
        turn_cw <= cmd.turn_cw;
        gyro_heading <= cmd.gyro_heading;
        half_speed <= cmd.half_speed;
        do
            @(posedge clk);
        while (!in_ready);
        pending_wheels.push_back(fixed ? known : mix_wheels(cmd));
        words_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 16);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_wheels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_gain(input logic [fomix_pkg::REG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            fomix_pkg::REG_GAIN_A: trim_gain[0] = data;
            fomix_pkg::REG_GAIN_B: trim_gain[1] = data;
            fomix_pkg::REG_GAIN_C: trim_gain[2] = data;
            default: ;
        endcase
        gain_writes++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        wheels_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_wheels.size() == 0)
            begin
                $error("result word with nothing expected: %0d %0d %0d",
                       wheel_a, wheel_b, wheel_c);
                err_count++;
            end
            else
            begin
                want = pending_wheels.pop_front();
                check_field("wheel_a", want.a, wheel_a);
                check_field("wheel_b", want.b, wheel_b);
                check_field("wheel_c", want.c, wheel_c);
                results_checked++;
            end
        end
        cycle_count++;
        ready_window--;
        if (ready_window <= 0)
        begin
            ready_window = $urandom_range(20, 90);
            ready_mode = $urandom_range(0, 3);
        end
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 9) < 7;
            2: out_ready <= $urandom_range(0, 3) == 0;
            default: out_ready <= (cycle_count % 5) == 0;
        endcase
    end

    initial
    begin : watchdog
        repeat (LIMIT) @(posedge clk);
        $display("field_oriented_three_omni_wheel_mix verification failed");
        $finish;
    end

    initial
    begin : main
        logic [15:0] ga;
        logic [15:0] gb;
        logic [15:0] gc;
        err_count = 0;
        words_sent = 0;
        results_checked = 0;
        gain_writes = 0;
        burst_left = 8;
        ready_mode = 0;
        ready_window = 0;
        cycle_count = 0;
        trim_gain[0] = TRIM_A_RST;
        trim_gain[1] = TRIM_B_RST;
        trim_gain[2] = TRIM_C_RST;
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        heading <= '0;
        travel_speed <= '0;
        turn_ccw <= '0;
        turn_cw <= '0;
        gyro_heading <= '0;
        half_speed <= 1'b0;
        out_ready <= 1'b0;

        // reset gains, zero and wrapped angles, cordic folds, extreme speeds and turns
        add_known(16'h0000, 16'h0000, 15'h0000, 15'h0000, 16'h0000, 1'b0, 16'd0, 16'd0, 16'd0);
        add_known(16'hFFFF, 16'h0000, 15'h0000, 15'h0000, 16'hFFFF, 1'b1, 16'd0, 16'd0, 16'd0);
        add_known(16'h1234, 16'h0000, 15'h7FFF, 15'h7FFF, 16'h9876, 1'b0, 16'd0, 16'd0, 16'd0);
        add_word(16'h0000, 16'h7FFF, 15'h0000, 15'h0000, 16'h0000, 1'b0);
        add_word(16'h4000, 16'h8000, 15'h0000, 15'h0000, 16'h0000, 1'b0);
        add_word(16'h4001, 16'h7FFF, 15'h0000, 15'h0000, 16'h0000, 1'b0);
        add_word(16'h8000, 16'h8000, 15'h0000, 15'h0000, 16'h0000, 1'b1);
        add_word(16'h0000, 16'h7FFF, 15'h0000, 15'h0000, 16'h4000, 1'b0);
        add_word(16'h0000, 16'h7FFF, 15'h0000, 15'h0000, 16'h3FFF, 1'b0);
        add_word(16'hC000, 16'h7FFF, 15'h7FFF, 15'h0000, 16'h0000, 1'b0);
        add_word(16'h2AAA, 16'h8000, 15'h0000, 15'h7FFF, 16'hFFFF, 1'b1);
        // full gains; a full turn at normal speed pushes every drive into saturation
        add_gain(fomix_pkg::REG_GAIN_A, 16'hFFFF);
        add_gain(fomix_pkg::REG_GAIN_B, 16'hFFFF);
        add_gain(fomix_pkg::REG_GAIN_C, 16'hFFFF);
        add_known(16'h0000, 16'h0000, 15'h7FFF, 15'h0000, 16'h0000, 1'b0,
                  16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_known(16'h0000, 16'h0000, 15'h0000, 15'h7FFF, 16'h0000, 1'b0,
                  16'h8000, 16'h8000, 16'h8000);
        add_word(16'h0000, 16'h0000, 15'h7FFF, 15'h0000, 16'h0000, 1'b1);
        add_word(16'h0000, 16'h7FFF, 15'h7FFF, 15'h0000, 16'h0000, 1'b0);
        add_word(16'hD555, 16'h8000, 15'h7FFF, 15'h0000, 16'h8000, 1'b0);
        // zero gains, then writes to unknown indexes must leave them alone
        add_gain(fomix_pkg::REG_GAIN_A, 16'h0000);
        add_gain(fomix_pkg::REG_GAIN_B, 16'h0000);
        add_gain(fomix_pkg::REG_GAIN_C, 16'h0000);
        add_known(16'h0000, 16'h7FFF, 15'h7FFF, 15'h0000, 16'h0000, 1'b0, 16'd0, 16'd0, 16'd0);
        add_gain(REG_UNUSED_LO, 16'hFFFF);
        add_gain(REG_UNUSED_HI, 16'h1234);
        add_known(16'h5555, 16'h8000, 15'h0000, 15'h7FFF, 16'h0000, 1'b1, 16'd0, 16'd0, 16'd0);
        add_gain(fomix_pkg::REG_GAIN_A, 16'h0001);
        add_gain(fomix_pkg::REG_GAIN_B, TRIM_UNITY);
        add_gain(fomix_pkg::REG_GAIN_C, 16'hFFFE);
        add_word(16'h1000, 16'h7FFF, 15'h0003, 15'h0000, 16'h0000, 1'b0);
        add_word(16'hF000, 16'h8000, 15'h0000, 15'h0003, 16'h0000, 1'b1);
        add_gain(fomix_pkg::REG_GAIN_A, TRIM_A_RST);
        add_gain(fomix_pkg::REG_GAIN_B, TRIM_B_RST);
        add_gain(fomix_pkg::REG_GAIN_C, TRIM_C_RST);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_GAIN)
            begin
                drain_results();
                write_gain(directed_rows[i].idx, directed_rows[i].data);
            end
            else
                send_word(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].wheels);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            case (p)
                0: begin ga = TRIM_A_RST; gb = TRIM_B_RST; gc = TRIM_C_RST; end
                1: begin ga = 16'hFFFF; gb = 16'hFFFF; gc = 16'hFFFF; end
                2: begin ga = 16'h0000; gb = 16'h0000; gc = 16'h0000; end
                3: begin ga = TRIM_UNITY; gb = TRIM_UNITY; gc = TRIM_UNITY; end
                default: begin ga = 16'($urandom); gb = 16'($urandom); gc = 16'($urandom); end
            endcase
            write_gain(8'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
            write_gain(fomix_pkg::REG_GAIN_C, gc);
            write_gain(fomix_pkg::REG_GAIN_A, ga);
            write_gain(fomix_pkg::REG_GAIN_B, gb);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == PHASE_WORDS / 2 && p % 3 == 1)
                    drain_results();
                send_word(random_command(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d words under %0d register writes, %0d results checked",
                 words_sent, gain_writes, results_checked);
        $display("directed rows: %0d, random gain phases: %0d", directed_rows.size(), NUM_PHASES);
        if (err_count == 0 && pending_wheels.size() == 0)
            $display("field_oriented_three_omni_wheel_mix verification clean");
        else
            $display("field_oriented_three_omni_wheel_mix verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/fomix_pkg.sv
rtl/core/fomix_cordic_cell.sv
rtl/core/fomix_drive.sv
rtl/core/field_oriented_three_omni_wheel_mix.sv
rtl/core/fomix_check.sv
bench/field_oriented_three_omni_wheel_mix_test.sv
